FILE: sv/pti_pkg.sv
`timescale 1ns / 1ps
package pti_pkg;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 6;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = CNT_W + 1;
  localparam int ADDR_W  = 4;
  localparam int QUO_W   = 40;

  localparam int ENTRY_SLOTS = 1 << ENTRY_W;

  // Q16.16 constants
  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;

  // register indexes
  localparam logic [1:0] REG_NPTS   = 2'd0;
  localparam logic [1:0] REG_METHOD = 2'd1;
  localparam logic [1:0] REG_TRANS  = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] query_x;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     valid_res;
    logic                     table_empty;
  } out_data_t;

  typedef struct packed {
    logic [CNT_W-1:0] npts;
    logic             method;
    logic             trans;
  } cfg_t;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_SCAN,
    ADDR_LEFT,
    ADDR_RIGHT
  } addr_sel_t;

  typedef enum logic [2:0] {
    RES_EMPTY,
    RES_FIRST,
    RES_LAST,
    RES_FIRST_VALID,
    RES_LEFT_VALID,
    RES_INTERP,
    RES_GAP
  } res_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RANGE,
    ST_SCAN,
    ST_PICK,
    ST_RD_RIGHT,
    ST_GOT_RIGHT,
    ST_DIV
  } state_t;

  typedef enum logic [2:0] {
    IP_IDLE,
    IP_MUL,
    IP_PREP,
    IP_DIV,
    IP_ADD
  } ip_state_t;

  typedef struct packed {
    logic      wr_en;
    logic      ld_q;
    addr_sel_t addr_sel;
    logic      ld_first;
    logic      scan_init;
    logic      scan_run;
    logic      ld_left;
    logic      div_start;
    logic      ld_res;
    res_sel_t  res_sel;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic below;
    logic above;
    logic scan_stop;
    logic cnt_odd;
    logic r_beyond;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/pti_regs.sv
`timescale 1ns / 1ps
module pti_regs
  import pti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CNT_W-1:0] npts_r;
  logic             method_r;
  logic             trans_r;
  logic             wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npts_r   <= '0;
      method_r <= 1'b0;
      trans_r  <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_NPTS:   npts_r   <= pwdata[CNT_W-1:0];
        REG_METHOD: method_r <= pwdata[0];
        REG_TRANS:  trans_r  <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_NPTS:   prdata = {{(32-CNT_W){1'b0}}, npts_r};
      REG_METHOD: prdata = {31'd0, method_r};
      REG_TRANS:  prdata = {31'd0, trans_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.npts   = npts_r;
  assign cfg.method = method_r;
  assign cfg.trans  = trans_r;

endmodule

FILE: sv/pti_interp.sv
`timescale 1ns / 1ps
module pti_interp
  import pti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] q,
  input  logic signed [DATA_W-1:0] xl,
  input  logic signed [DATA_W-1:0] yl,
  input  logic signed [DATA_W-1:0] xr,
  input  logic signed [DATA_W-1:0] yr,
  output logic                     done,
  output logic [DATA_W-1:0]        res
);

  ip_state_t ph_r, ph_nxt;

  logic [DATA_W-1:0]   a_r, b_r, d_r;
  logic                neg_r, zero_r, ovf_r;
  logic [DATA_W-1:0]   yl_r;
  logic [2*DATA_W-1:0] p_r;
  logic [DATA_W-1:0]   rem_r;
  logic [QUO_W-1:0]    sh_r;
  logic [5:0]          it_r;
  logic                done_r;
  logic [DATA_W-1:0]   res_r;

  logic signed [DATA_W:0] dy, dq, dx;
  logic [DATA_W:0]        dy_mag, dq_mag, dx_mag;
  logic                   ovf_c;
  logic [DATA_W:0]        trial, diff;
  logic                   ge;
  logic signed [QUO_W+1:0] yl_ext, quo_ext, sum;
  logic [DATA_W-1:0]      sat;

  // differences and magnitudes
  always_comb begin
    dy     = {yr[DATA_W-1], yr} - {yl[DATA_W-1], yl};
    dq     = {q[DATA_W-1], q} - {xl[DATA_W-1], xl};
    dx     = {xr[DATA_W-1], xr} - {xl[DATA_W-1], xl};
    dy_mag = dy[DATA_W] ? (33'd0 - dy) : dy;
    dq_mag = dq[DATA_W] ? (33'd0 - dq) : dq;
    dx_mag = dx[DATA_W] ? (33'd0 - dx) : dx;
  end

  // quotient bits above bit 39 are set exactly when the top of the product reaches d
  assign ovf_c = {{(DATA_W-(2*DATA_W-QUO_W)){1'b0}}, p_r[2*DATA_W-1:QUO_W]} >= d_r;

  // one restoring division step
  always_comb begin
    trial = {rem_r, sh_r[QUO_W-1]};
    ge    = trial >= {1'b0, d_r};
    diff  = trial - {1'b0, d_r};
  end

  // final add and saturation
  always_comb begin
    yl_ext  = {{(QUO_W+2-DATA_W){yl_r[DATA_W-1]}}, yl_r};
    quo_ext = {2'b00, sh_r};
    sum     = neg_r ? (yl_ext - quo_ext) : (yl_ext + quo_ext);
    if (sum[QUO_W+1:DATA_W-1] != {(QUO_W+3-DATA_W){sum[QUO_W+1]}})
      sat = sum[QUO_W+1] ? Q_MIN : Q_MAX;
    else
      sat = sum[DATA_W-1:0];
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= IP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == IP_ADD);
    end
  end

  // phase sequencing
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      IP_IDLE: if (start) ph_nxt = IP_MUL;
      IP_MUL:  ph_nxt = zero_r ? IP_ADD : IP_PREP;
      IP_PREP: ph_nxt = ovf_c ? IP_ADD : IP_DIV;
      IP_DIV:  if (it_r == '0) ph_nxt = IP_ADD;
      IP_ADD:  ph_nxt = IP_IDLE;
      default: ph_nxt = IP_IDLE;
    endcase
  end

  // operand, product and division registers
  always_ff @(posedge clk) begin
    case (ph_r)
      IP_IDLE: begin
        if (start) begin
          a_r    <= dy_mag[DATA_W-1:0];
          b_r    <= dq_mag[DATA_W-1:0];
          d_r    <= dx_mag[DATA_W-1:0];
          neg_r  <= (dy[DATA_W] ^ dq[DATA_W]) ^ dx[DATA_W];
          zero_r <= (dx == '0);
          yl_r   <= yl;
          ovf_r  <= 1'b0;
        end
      end
      IP_MUL: begin
        p_r <= a_r * b_r;
      end
      IP_PREP: begin
        ovf_r <= ovf_c;
        rem_r <= {{(DATA_W-(2*DATA_W-QUO_W)){1'b0}}, p_r[2*DATA_W-1:QUO_W]};
        sh_r  <= p_r[QUO_W-1:0];
        it_r  <= 6'(QUO_W - 1);
      end
      IP_DIV: begin
        rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        sh_r  <= {sh_r[QUO_W-2:0], ge};
        it_r  <= it_r - 6'd1;
      end
      IP_ADD: begin
        if (zero_r)     res_r <= yl_r;
        else if (ovf_r) res_r <= neg_r ? Q_MIN : Q_MAX;
        else            res_r <= sat;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: sv/pti_datapath.sv
`timescale 1ns / 1ps
module pti_datapath
  import pti_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  cfg_t      cfg,
  input  in_data_t  in_data,
  output sts_t      sts,
  output out_data_t out_data,
  output logic      out_strobe
);

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int N_CAP_I = (TABLE_DEPTH > CNT_MAX) ? CNT_MAX : TABLE_DEPTH;
  localparam logic [CNT_W-1:0] N_CAP = N_CAP_I[CNT_W-1:0];
  localparam int MEM_D = (TABLE_DEPTH < ENTRY_SLOTS) ? TABLE_DEPTH : ENTRY_SLOTS;
  localparam int AW    = $clog2(MEM_D);

  logic [2*DATA_W-1:0] mem [MEM_D];
  logic [2*DATA_W-1:0] rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;

  logic signed [DATA_W-1:0] q_r, x0_r, y0_r, xl_r, yl_r;
  logic signed [DATA_W-1:0] rd_x, rd_y;

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] n_ext;
  logic [IDX_W-1:0] ia_r, ci_r, cnt_r, l_r, r_r;
  logic             cv_r, iss_done_r;
  logic [IDX_W-1:0] step, ia_adv, cnt_nxt;
  logic             gt, hit_cont, last_tr, stop;

  logic             ip_done;
  logic [DATA_W-1:0] ip_res;

  out_data_t out_data_r;
  logic      out_strobe_r;

  assign n_eff   = (cfg.npts > N_CAP) ? N_CAP : cfg.npts;
  assign n_ext   = {1'b0, n_eff};
  assign wr_addr = in_data.entry_index[AW-1:0];
  assign rd_x    = rd_data_r[2*DATA_W-1:DATA_W];
  assign rd_y    = rd_data_r[DATA_W-1:0];

  // read address select
  always_comb begin
    case (cmd.addr_sel)
      ADDR_ZERO:  rd_addr = '0;
      ADDR_LAST:  rd_addr = AW'(n_eff - CNT_W'(1));
      ADDR_SCAN:  rd_addr = ia_r[AW-1:0];
      ADDR_LEFT:  rd_addr = l_r[AW-1:0];
      ADDR_RIGHT: rd_addr = r_r[AW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  // breakpoint memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (int'(in_data.entry_index) < TABLE_DEPTH))
      mem[wr_addr] <= {in_data.entry_x, in_data.entry_y};
    rd_data_r <= mem[rd_addr];
  end

  // query, first and left entries
  always_ff @(posedge clk) begin
    if (cmd.ld_q) q_r <= in_data.query_x;
    if (cmd.ld_first) begin
      x0_r <= rd_x;
      y0_r <= rd_y;
    end
    if (cmd.ld_left) begin
      xl_r <= rd_x;
      yl_r <= rd_y;
    end
  end

  // scan compare
  always_comb begin
    step     = cfg.trans ? IDX_W'(2) : IDX_W'(1);
    ia_adv   = ia_r + step;
    gt       = q_r > rd_x;
    cnt_nxt  = cnt_r + IDX_W'(gt);
    hit_cont = (ci_r == (n_ext - IDX_W'(1))) || !gt;
    last_tr  = (ci_r + IDX_W'(2)) >= n_ext;
    stop     = cv_r && (cfg.trans ? last_tr : hit_cont);
  end

  // scan pipeline: issue one address a cycle, check its data the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r       <= 1'b0;
      iss_done_r <= 1'b0;
    end else if (cmd.scan_init) begin
      ia_r       <= cfg.trans ? IDX_W'(0) : IDX_W'(1);
      cv_r       <= 1'b0;
      iss_done_r <= 1'b0;
      cnt_r      <= '0;
    end else if (cmd.scan_run) begin
      if (!iss_done_r) begin
        ci_r       <= ia_r;
        cv_r       <= 1'b1;
        ia_r       <= ia_adv;
        iss_done_r <= ia_adv >= n_ext;
      end else begin
        cv_r <= 1'b0;
      end
      if (cv_r) begin
        cnt_r <= cnt_nxt;
        if (stop) begin
          if (cfg.trans) begin
            l_r <= (cnt_nxt - IDX_W'(1)) << 1;
            r_r <= cnt_nxt << 1;
          end else begin
            l_r <= ci_r - IDX_W'(1);
            r_r <= ci_r;
          end
        end
      end
    end
  end

  // multiply and divide unit
  pti_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .q     (q_r),
    .xl    (xl_r),
    .yl    (yl_r),
    .xr    (rd_x),
    .yr    (rd_y),
    .done  (ip_done),
    .res   (ip_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.ld_res;
    end
    if (cmd.ld_res) begin
      case (cmd.res_sel)
        RES_EMPTY:       out_data_r <= '{value: Q_ONE, valid_res: 1'b0, table_empty: 1'b1};
        RES_FIRST:       out_data_r <= '{value: y0_r, valid_res: 1'b0, table_empty: 1'b0};
        RES_LAST:        out_data_r <= '{value: rd_y, valid_res: 1'b0, table_empty: 1'b0};
        RES_FIRST_VALID: out_data_r <= '{value: y0_r, valid_res: 1'b1, table_empty: 1'b0};
        RES_LEFT_VALID:  out_data_r <= '{value: yl_r, valid_res: 1'b1, table_empty: 1'b0};
        RES_INTERP:      out_data_r <= '{value: ip_res, valid_res: 1'b1, table_empty: 1'b0};
        RES_GAP:         out_data_r <= '{value: Q_NEG_ONE, valid_res: 1'b0, table_empty: 1'b0};
        default:         out_data_r <= '{value: Q_ONE, valid_res: 1'b0, table_empty: 1'b1};
      endcase
    end
  end

  // status back to the controller
  assign sts.n_zero    = (n_eff == '0);
  assign sts.n_one     = (n_eff == CNT_W'(1));
  assign sts.below     = q_r < x0_r;
  assign sts.above     = q_r > rd_x;
  assign sts.scan_stop = stop;
  assign sts.cnt_odd   = cnt_r[0];
  assign sts.r_beyond  = r_r >= n_ext;
  assign sts.div_done  = ip_done;

  assign out_data   = out_data_r;
  assign out_strobe = out_strobe_r;

endmodule

FILE: sv/pti_ctrl.sv
`timescale 1ns / 1ps
module pti_ctrl
  import pti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic mode,
  input  cfg_t cfg,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_ZERO;
    cmd.res_sel  = RES_EMPTY;
    case (state_r)
      ST_IDLE: begin
        cmd.addr_sel = ADDR_ZERO;
        if (start) begin
          if (!mode) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.ld_q = 1'b1;
            if (sts.n_zero) begin
              cmd.ld_res  = 1'b1;
              cmd.res_sel = RES_EMPTY;
            end else begin
              state_nxt = ST_RD_LAST;
            end
          end
        end
      end
      ST_RD_LAST: begin
        cmd.ld_first = 1'b1;
        cmd.addr_sel = ADDR_LAST;
        state_nxt    = ST_RANGE;
      end
      ST_RANGE: begin
        if (sts.below) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_FIRST;
          state_nxt   = ST_IDLE;
        end else if (sts.above) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_LAST;
          state_nxt   = ST_IDLE;
        end else if (!cfg.trans && sts.n_one) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_FIRST_VALID;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.addr_sel = ADDR_SCAN;
        cmd.scan_run = 1'b1;
        if (sts.scan_stop) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.addr_sel = ADDR_LEFT;
        if (cfg.trans && !sts.cnt_odd) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_GAP;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_RD_RIGHT;
        end
      end
      ST_RD_RIGHT: begin
        cmd.addr_sel = ADDR_RIGHT;
        cmd.ld_left  = 1'b1;
        state_nxt    = ST_GOT_RIGHT;
      end
      ST_GOT_RIGHT: begin
        if ((!cfg.trans && cfg.method) || (cfg.trans && sts.r_beyond)) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_LEFT_VALID;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.ld_res  = 1'b1;
          cmd.res_sel = RES_INTERP;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: sv/piecewise_table_interpolator.sv
`timescale 1ns / 1ps
// channel   | ports                                     | beat marked by
// ----------+-------------------------------------------+-------------------------------
// input     | start, busy, in_data                      | start high while busy low
// result    | out_strobe, out_data                      | out_strobe, one cycle
// config    | psel, penable, pwrite, paddr, pwdata,     | psel & penable & pwrite
//           | prdata, pready                            |
//
// a table write is accepted while busy stays low; a query on an empty table also
// finishes in the accept cycle. other queries take longer, set by the one-entry-a-cycle
// scan of the breakpoint memory and the 40-step bit-serial divider. the receiver
// cannot stall the result beat. rst_n is synchronous and clears the configuration
// registers, the result strobe and control; table contents are undefined until written.
module piecewise_table_interpolator
  import pti_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_data_t          in_data,
  output logic              out_strobe,
  output out_data_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  pti_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencing
  pti_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .cfg   (cfg),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table, scan and arithmetic
  pti_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_data    (in_data),
    .sts        (sts),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

endmodule

FILE: tb/sv/piecewise_table_interpolator_tb.sv
`timescale 1ns / 1ps
module piecewise_table_interpolator_tb;
  import pti_pkg::*;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   ITEM_GOAL  = 950;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    in_data_t   item;
    logic [1:0] reg_idx;
    logic [31:0] reg_val;
    bit         typed;
    out_data_t  want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_data_t          in_data;
  logic              out_strobe;
  out_data_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // breakpoint table and register copy kept by the testbench
  logic signed [DATA_W-1:0] bp_x [ENTRY_SLOTS];
  logic signed [DATA_W-1:0] bp_y [ENTRY_SLOTS];
  logic [CNT_W-1:0]         cfg_npts   = '0;
  logic                     cfg_method = 1'b0;
  logic                     cfg_trans  = 1'b0;

  out_data_t awaited_results[$];
  stim_row_t directed_rows[$];
  int        fail_count = 0;
  int        items_sent = 0;
  bit        allow_gaps = 1'b1;

  piecewise_table_interpolator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // append to the expected results and to the directed table
  function automatic void note_expected(input out_data_t res);
    awaited_results = {awaited_results, res};
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  // yl + trunc(dy * dq / dx) over one interval, saturated
  function automatic logic signed [DATA_W-1:0] segment_value(input longint q, input int l,
                                                             input int r);
    longint      dx, dy, dq, s;
    logic [63:0] a, b, d;
    logic [67:0] prod, quo;
    bit          neg;
    dx = longint'(bp_x[r]) - longint'(bp_x[l]);
    if (dx == 0) return bp_y[l];
    dy = longint'(bp_y[r]) - longint'(bp_y[l]);
    dq = q - longint'(bp_x[l]);
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    a = (dy < 0) ? -dy : dy;
    b = (dq < 0) ? -dq : dq;
    d = (dx < 0) ? -dx : dx;
    prod = a * b;
    quo = prod / d;
    // quotient too wide for the 40-bit divider saturates by sign
    if (quo[67:40] != '0) return neg ? Q_MIN : Q_MAX;
    s = neg ? longint'(bp_y[l]) - longint'(quo[39:0]) : longint'(bp_y[l]) + longint'(quo[39:0]);
    return clamp32(s);
  endfunction

  // expected result of one query under the current table and registers
  function automatic out_data_t interpolate_at(input logic signed [DATA_W-1:0] qx);
    out_data_t res;
    int        n, i, cnt, l, r;
    n = (cfg_npts > ENTRY_SLOTS) ? ENTRY_SLOTS : int'(cfg_npts);
    res.value = '0;
    res.valid_res = 1'b1;
    res.table_empty = 1'b0;
    if (n == 0) begin
      res.value = Q_ONE;
      res.valid_res = 1'b0;
      res.table_empty = 1'b1;
    end else if (qx < bp_x[0]) begin
      res.value = bp_y[0];
      res.valid_res = 1'b0;
    end else if (qx > bp_x[n-1]) begin
      res.value = bp_y[n-1];
      res.valid_res = 1'b0;
    end else if (!cfg_trans) begin
      if (n == 1) begin
        res.value = bp_y[0];
      end else begin
        i = 1;
        while (i < n - 1 && qx > bp_x[i]) i++;
        res.value = cfg_method ? bp_y[i-1] : segment_value(longint'(qx), i - 1, i);
      end
    end else begin
      // transient: count even entries left of the query
      cnt = 0;
      for (int j = 0; j < n; j += 2)
        if (qx > bp_x[j]) cnt++;
      if (cnt % 2 == 1) begin
        l = (cnt - 1) * 2;
        r = cnt * 2;
        res.value = (r >= n) ? bp_y[l] : segment_value(longint'(qx), l, r);
      end else begin
        res.value = Q_NEG_ONE;
        res.valid_res = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t item_row(input logic mode, input logic [ENTRY_W-1:0] idx,
                                         input logic [31:0] ex, input logic [31:0] ey,
                                         input logic [31:0] qx, input bit typed,
                                         input out_data_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.item.mode = mode;
    row.item.entry_index = idx;
    row.item.entry_x = ex;
    row.item.entry_y = ey;
    row.item.query_x = qx;
    row.reg_idx = REG_NPTS;
    row.reg_val = '0;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = item_row(MODE_WRITE, '0, '0, '0, '0, 1'b0, '0);
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // drive one beat on the input channel and record what it should cause
  task automatic send_item(input in_data_t item, input bit use_typed,
                           input out_data_t typed_res, input bit drain_first);
    int gap;
    gap = allow_gaps ? $urandom_range(0, 5) : 0;
    if (drain_first) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      while (drain_first && awaited_results.size() != 0) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    items_sent++;
    if (item.mode == MODE_WRITE) begin
      bp_x[item.entry_index] = item.entry_x;
      bp_y[item.entry_index] = item.entry_y;
    end else begin
      note_expected(use_typed ? typed_res : interpolate_at(item.query_x));
    end
  endtask

  // stop sending and let the block finish everything in flight
  task automatic settle_idle();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NPTS:   cfg_npts = val[CNT_W-1:0];
      REG_METHOD: cfg_method = val[0];
      REG_TRANS:  cfg_trans = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // rewrite all entries with ascending x
  task automatic load_sorted_table();
    longint   x;
    int       step_cap;
    bit       small_y;
    in_data_t it;
    x = longint'($urandom_range(0, 32'h4000_0000)) - 64'sd2147483648;
    step_cap = 1 << $urandom_range(0, 25);
    small_y = 1'($urandom_range(0, 1));
    for (int k = 0; k < ENTRY_SLOTS; k++) begin
      it.mode = MODE_WRITE;
      it.entry_index = ENTRY_W'(k);
      it.entry_x = x[31:0];
      it.entry_y = small_y ? $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000 : $urandom;
      it.query_x = $urandom;
      send_item(it, 1'b0, '0, 1'b0);
      x += longint'($urandom_range(0, step_cap));
    end
  endtask

  function automatic logic [31:0] pick_query();
    int     n, k;
    longint lo, hi, d;
    n = (cfg_npts > ENTRY_SLOTS) ? ENTRY_SLOTS : int'(cfg_npts);
    if (n == 0) return $urandom;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      2, 3, 4: begin
        d = longint'($urandom_range(0, 64)) - 32;
        return clamp32(longint'(bp_x[k]) + d * longint'(1 << $urandom_range(0, 12)));
      end
      5, 6: return bp_x[k];
      default: begin
        if (n < 2) return bp_x[k];
        k = $urandom_range(0, n - 2);
        lo = bp_x[k];
        hi = bp_x[k+1];
        return clamp32(lo + (hi - lo) * longint'($urandom_range(0, 1024)) / 1024);
      end
    endcase
  endfunction

  // result channel: every beat must match the oldest expectation
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, out_data.value);
          fail_count++;
        end
        if (out_data.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time, want.valid_res,
                   out_data.valid_res);
          fail_count++;
        end
        if (out_data.table_empty !== want.table_empty) begin
          $display("%0t: table_empty expected %b actual %b", $time, want.table_empty,
                   out_data.table_empty);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_data_t it;
    longint   d;
    int       k, npts_sel, burst, phase;
    bit       meth_sel, trans_sel;

    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, search cases, hold, transient gaps
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h7FFF_FFFF, 1'b1, {Q_ONE, 1'b0, 1'b1}));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h8000_0000, 1'b1, {Q_ONE, 1'b0, 1'b1}));
    add_row(item_row(MODE_WRITE, 6'd0, 32'hFFF0_0000, 32'h7FFF_FFFF, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd1, 32'hFFF8_0000, 32'h8000_0000, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd2, 32'h0000_0000, 32'h0000_0000, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd3, 32'h0000_0000, 32'h0005_0000, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd4, 32'h0010_0000, 32'h0001_0000, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd5, 32'h7FFF_FFFF, 32'hFFFF_0000, '0, 1'b0, '0));
    add_row(item_row(MODE_WRITE, 6'd63, 32'h8000_0000, 32'h1234_5678, '0, 1'b0, '0));
    add_row(reg_row(REG_NPTS, 32'd6));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h8000_0000, 1'b1,
                     {32'h7FFF_FFFF, 1'b0, 1'b0}));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'hFFF0_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'hFFF4_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h0000_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h0008_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h7FFF_FFFF, 1'b0, '0));
    add_row(reg_row(REG_METHOD, 32'd1));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'hFFF4_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h0008_0000, 1'b0, '0));
    add_row(reg_row(REG_METHOD, 32'd0));
    add_row(reg_row(REG_TRANS, 32'd1));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'hFFF4_0000, 1'b0, '0));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h0008_0000, 1'b1,
                     {Q_NEG_ONE, 1'b0, 1'b0}));
    // right even entry past the count keeps the left y
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h7FFF_FFFF, 1'b0, '0));
    add_row(reg_row(REG_TRANS, 32'd0));
    add_row(reg_row(REG_NPTS, 32'd1));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'hFFF0_0000, 1'b1,
                     {32'h7FFF_FFFF, 1'b1, 1'b0}));
    add_row(item_row(MODE_QUERY, '0, '0, '0, 32'h0000_0000, 1'b1,
                     {32'h7FFF_FFFF, 1'b0, 1'b0}));

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        settle_idle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want, 1'b0);
      end
    end

    // every entry written before any count can reach it
    settle_idle();
    load_sorted_table();

    // random phases, each under one register setting
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      settle_idle();
      case (phase)
        0: begin npts_sel = 64;  meth_sel = 1'b0; trans_sel = 1'b0; end
        1: begin npts_sel = 127; meth_sel = 1'b1; trans_sel = 1'b0; end
        2: begin npts_sel = 65;  meth_sel = 1'b0; trans_sel = 1'b1; end
        3: begin npts_sel = 2;   meth_sel = 1'b0; trans_sel = 1'b1; end
        4: begin npts_sel = 1;   meth_sel = 1'b1; trans_sel = 1'b1; end
        5: begin npts_sel = 0;   meth_sel = 1'b0; trans_sel = 1'b0; end
        6: begin npts_sel = 64;  meth_sel = 1'b1; trans_sel = 1'b1; end
        default: begin
          npts_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 64);
          meth_sel = 1'($urandom_range(0, 1));
          trans_sel = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_NPTS, ($urandom & 32'hFFFF_FF80) | npts_sel);
      write_reg(REG_METHOD, ($urandom & 32'hFFFF_FFFE) | meth_sel);
      write_reg(REG_TRANS, ($urandom & 32'hFFFF_FFFE) | trans_sel);
      if (phase > 0 && $urandom_range(0, 2) == 0) load_sorted_table();
      allow_gaps = (phase % 3) != 2;
      burst = $urandom_range(60, 110);
      for (int b = 0; b < burst && items_sent < ITEM_GOAL; b++) begin
        it.entry_index = ENTRY_W'($urandom_range(0, ENTRY_SLOTS - 1));
        it.entry_x = $urandom;
        it.entry_y = $urandom;
        it.query_x = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          it.mode = MODE_WRITE;
          // mostly small moves that keep the table near ascending
          if ($urandom_range(0, 4) != 0) begin
            k = int'(it.entry_index);
            d = longint'($urandom_range(0, 2048)) - 1024;
            it.entry_x = clamp32(longint'(bp_x[k]) + d * longint'(1 << $urandom_range(0, 10)));
          end
        end else begin
          it.mode = MODE_QUERY;
          it.query_x = pick_query();
        end
        send_item(it, 1'b0, '0, $urandom_range(0, 39) == 0);
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
